FILE: src/verified_block_bitmap_unit_assert.svh
// Assertion macros shared by the bitmap unit's checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef VERIFIED_BLOCK_BITMAP_UNIT_ASSERT_SVH
`define VERIFIED_BLOCK_BITMAP_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define VBB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define VBB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define VBB_ASSERT_NEXT_ANY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/vbb_pkg.sv
// Package for the verified block bitmap unit: constants, request codes,
// sequencer state type, word unit result type and a leading-ones counter.
package vbb_pkg;

   localparam int WORD_BITS = 64;
   localparam int OFF_BITS  = 6;

   localparam logic [63:0] WORD_ONES = '1;
   localparam logic [63:0] WORD_MSB  = 64'h8000_0000_0000_0000;

   localparam logic [1:0] FN_SET   = 2'd0;
   localparam logic [1:0] FN_TEST  = 2'd1;
   localparam logic [1:0] FN_RUN   = 2'd2;
   localparam logic [1:0] FN_CLEAR = 2'd3;

   localparam logic [12:0] BITS_RESET      = 13'd4096;
   localparam logic        REG_BITS_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_WALK,
      ST_RESULT
   } fsm_state_type;

   typedef struct packed {
      logic [63:0] set_word;
      logic [63:0] clr_word;
      logic        bit_val;
      logic        run_stop;
      logic        run_full;
      logic [12:0] run_len;
      logic        clr_last;
   } word_result_type;

   // Number of consecutive ones from the most significant bit, 0 to 64.
   function automatic logic [6:0] lead_ones(input logic [63:0] v);
      logic [63:0] x;
      logic [6:0]  n;
      x = v;
      n = '0;
      if (&x) begin
         n = 7'd64;
      end else begin
         if (&x[63:32]) begin
            n = n + 7'd32;
            x = x << 32;
         end
         if (&x[63:48]) begin
            n = n + 7'd16;
            x = x << 16;
         end
         if (&x[63:56]) begin
            n = n + 7'd8;
            x = x << 8;
         end
         if (&x[63:60]) begin
            n = n + 7'd4;
            x = x << 4;
         end
         if (&x[63:62]) begin
            n = n + 7'd2;
            x = x << 2;
         end
         if (x[63]) begin
            n = n + 7'd1;
         end
      end
      return n;
   endfunction

endpackage

FILE: src/vbb_ifs.sv
// Handshake channels of the bitmap unit: the request channel and the result channel.
// Stand-alone; no package needed.
interface vbb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [11:0] start_offset;
   logic [12:0] range_end;

   modport source (output valid, output func, output start_offset, output range_end,
                   input ready);
   modport sink (input valid, input func, input start_offset, input range_end,
                 output ready);
endinterface

interface vbb_rsp_if;
   logic        valid;
   logic        ready;
   logic        bit_is_set;
   logic [12:0] run_length;
   logic        all_set;

   modport source (output valid, output bit_is_set, output run_length, output all_set,
                   input ready);
   modport sink (input valid, input bit_is_set, input run_length, input all_set,
                 output ready);
endinterface

FILE: src/vbb_mem.sv
// Word store of the bitmap: one write port and one registered read port.
// No package needed.
module vbb_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem_ff [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/vbb_word_unit.sv
// Shared word unit: sets, tests, scans for the first clear bit and builds clear masks
// on one 64-bit word of the bitmap. Depends on vbb_pkg.
module vbb_word_unit #(
   parameter int AW = 6,
   parameter int VW = 14
) (
   input  logic [63:0]              word_data,
   input  logic [AW-1:0]            word_idx,
   input  logic [11:0]              start_offset,
   input  logic [12:0]              range_end,
   output vbb_pkg::word_result_type result
);
   import vbb_pkg::*;

   logic [AW-1:0] start_word;
   logic [5:0]    lo_off;
   logic [6:0]    hi_off;
   logic [6:0]    lones;
   logic [VW-1:0] base;
   logic [VW-1:0] pos;
   logic [VW-1:0] start_v;
   logic [VW-1:0] end_v;
   logic [VW-1:0] diff;
   logic [63:0]   single;
   logic [63:0]   fill;
   logic [63:0]   clr_mask;
   logic          full;

   always_comb begin
      start_word = AW'(start_offset[11:6]);
      // Only the first word of a range starts part way in.
      lo_off  = (word_idx == start_word) ? start_offset[5:0] : '0;
      base    = VW'({word_idx, 6'b0});
      start_v = VW'(start_offset);
      end_v   = VW'(range_end);
      single  = WORD_MSB >> start_offset[5:0];

      // Bits ahead of the range count as set so the scan starts at the range.
      fill  = ~(WORD_ONES >> lo_off);
      lones = lead_ones(word_data | fill);
      pos   = base + VW'(lones);
      full  = (pos >= end_v);

      diff     = end_v - base;
      hi_off   = (diff >= VW'(WORD_BITS)) ? 7'(WORD_BITS) : diff[6:0];
      clr_mask = (WORD_ONES >> lo_off) & ~(WORD_ONES >> hi_off);

      result.set_word = word_data | single;
      result.clr_word = word_data & ~clr_mask;
      result.bit_val  = |(word_data & single);
      result.run_full = full;
      result.run_stop = full || (lones != 7'(WORD_BITS));
      result.run_len  = 13'((full ? end_v : pos) - start_v);
      result.clr_last = (diff <= VW'(WORD_BITS));
   end

endmodule

FILE: src/verified_block_bitmap_unit.sv
// Block bitmap with set, test, run measure and range clear, MAX_BITS bits in 64-bit
// words, most significant bit first. After reset the word store is cleared one word per
// cycle with req_bus.ready low. One item is in work at a time: set and test pass
// through the fetch, walk and result states; run measure and clear pass through fetch,
// then stay in walk while the single word unit handles one word of the store per
// cycle, then go to result. An empty or out-of-range request goes straight from idle
// to result, and the result state loads the output register once that is free.
// req_bus.ready is high again from the cycle in which the result appears. The result
// waits in an output register, so a new item is taken while it is still held. Depends
// on vbb_pkg, vbb_ifs, vbb_mem and vbb_word_unit.
module verified_block_bitmap_unit #(
   parameter int MAX_BITS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   vbb_req_if.sink          req_bus,
   vbb_rsp_if.source        rsp_bus,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import vbb_pkg::*;

   localparam int MAP_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PW        = AW + OFF_BITS;
   localparam int VW        = ((PW > 13) ? PW : 13) + 1;
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

   fsm_state_type   state_ff, state_in;
   logic [12:0]     bits_ff;
   logic [1:0]      func_ff, func_in;
   logic [11:0]     start_ff, start_in;
   logic [12:0]     end_ff, end_in;
   logic [AW-1:0]   ptr_ff, ptr_in;
   logic [AW-1:0]   eval_ff, eval_in;
   logic            res_bit_ff, res_bit_in;
   logic [12:0]     res_run_ff, res_run_in;
   logic            res_all_ff, res_all_in;
   logic            out_valid_ff, out_valid_in;
   logic            out_bit_ff, out_bit_in;
   logic [12:0]     out_run_ff, out_run_in;
   logic            out_all_ff, out_all_in;

   logic            csr_write;
   logic [12:0]     lim;
   logic [12:0]     end_c;
   logic            in_bounds;
   logic            nonempty;
   logic            go_walk;
   logic            accept;
   logic            out_free;
   logic            walk_done;

   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [63:0]     mem_wdata;
   logic [AW-1:0]   mem_raddr;
   logic [63:0]     mem_rdata;
   word_result_type wres;

   // Configuration port.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BITS_IN_USE) ? 32'(bits_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= BITS_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_BITS_IN_USE)) begin
         bits_ff <= csr_pwdata[12:0];
      end
   end

   // Request decode at acceptance.
   always_comb begin
      lim       = (32'(bits_ff) > MAX_BITS) ? 13'(MAX_BITS) : bits_ff;
      end_c     = (req_bus.range_end > lim) ? lim : req_bus.range_end;
      in_bounds = ({1'b0, req_bus.start_offset} < lim);
      nonempty  = ({1'b0, req_bus.start_offset} < end_c);
      go_walk   = ((req_bus.func == FN_SET) || (req_bus.func == FN_TEST)) ? in_bounds
                                                                          : nonempty;
      accept    = req_bus.valid && req_bus.ready;
      out_free  = !out_valid_ff || rsp_bus.ready;
   end

   always_comb begin
      case (func_ff)
         FN_RUN:   walk_done = wres.run_stop;
         FN_CLEAR: walk_done = wres.clr_last;
         default:  walk_done = 1'b1;
      endcase
   end

   vbb_mem #(
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   vbb_word_unit #(
      .AW (AW),
      .VW (VW)
   ) u_word_unit (
      .word_data    (mem_rdata),
      .word_idx     (eval_ff),
      .start_offset (start_ff),
      .range_end    (end_ff),
      .result       (wres)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = go_walk ? ST_FETCH : ST_RESULT;
            end
         end
         ST_FETCH: state_in = ST_WALK;
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Sequencer outputs and datapath register updates.
   always_comb begin
      func_in       = func_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      ptr_in        = ptr_ff;
      eval_in       = eval_ff;
      res_bit_in    = res_bit_ff;
      res_run_in    = res_run_ff;
      res_all_in    = res_all_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_bit_in    = out_bit_ff;
      out_run_in    = out_run_ff;
      out_all_in    = out_all_ff;
      mem_we        = 1'b0;
      mem_waddr     = eval_ff;
      mem_wdata     = wres.set_word;
      mem_raddr     = ptr_ff;
      req_bus.ready = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = '0;
            ptr_in    = ptr_ff + AW'(1);
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (accept) begin
               func_in    = req_bus.func;
               start_in   = req_bus.start_offset;
               end_in     = end_c;
               ptr_in     = AW'(req_bus.start_offset[11:6]);
               res_bit_in = 1'b0;
               res_run_in = '0;
               // An empty range counts as fully set.
               res_all_in = (req_bus.func == FN_RUN);
            end
         end
         ST_FETCH: begin
            ptr_in  = ptr_ff + AW'(1);
            eval_in = ptr_ff;
         end
         ST_WALK: begin
            ptr_in  = ptr_ff + AW'(1);
            eval_in = ptr_ff;
            case (func_ff)
               FN_SET: begin
                  mem_we    = 1'b1;
                  mem_wdata = wres.set_word;
               end
               FN_TEST: res_bit_in = wres.bit_val;
               FN_RUN: begin
                  if (wres.run_stop) begin
                     res_run_in = wres.run_len;
                     res_all_in = wres.run_full;
                  end
               end
               default: begin
                  mem_we    = 1'b1;
                  mem_wdata = wres.clr_word;
               end
            endcase
         end
         ST_RESULT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_bit_in   = res_bit_ff;
               out_run_in   = res_run_ff;
               out_all_in   = res_all_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      start_ff   <= start_in;
      end_ff     <= end_in;
      eval_ff    <= eval_in;
      res_bit_ff <= res_bit_in;
      res_run_ff <= res_run_in;
      res_all_ff <= res_all_in;
      out_bit_ff <= out_bit_in;
      out_run_ff <= out_run_in;
      out_all_ff <= out_all_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.bit_is_set = out_bit_ff;
   assign rsp_bus.run_length = out_run_ff;
   assign rsp_bus.all_set    = out_all_ff;

endmodule

FILE: src/vbb_checker.sv
// Port-level checks for the bitmap unit, bound to the top level.
// Depends on verified_block_bitmap_unit_assert.svh and the top level's ports.
`include "verified_block_bitmap_unit_assert.svh"

module vbb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_bit_is_set,
   input logic [12:0] rsp_run_length,
   input logic        rsp_all_set
);

   logic mixed_fields;

   assign mixed_fields = rsp_bit_is_set && (rsp_all_set || (rsp_run_length != 13'd0));

   // The word store is being cleared straight after reset.
   `VBB_ASSERT_NEXT_ANY(a_busy_after_reset, reset, !req_ready, "ready high after reset")

   // Only one item is in work at a time.
   `VBB_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "ready after accept")

   `VBB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result item dropped")

   // A test result never carries run measure fields.
   `VBB_ASSERT_NOW(a_rsp_fields, rsp_valid, !mixed_fields, "mixed result fields")

endmodule

bind verified_block_bitmap_unit vbb_checker u_vbb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_bit_is_set (rsp_bus.bit_is_set),
   .rsp_run_length (rsp_bus.run_length),
   .rsp_all_set    (rsp_bus.all_set)
);
